// ===== rtl/sbct_pkg.sv =====
// Shared types and constants of the swept box collision time block.
// Used by sbct_div, swept_box_collision_time_top and sbct_checker; no dependencies.
package sbct_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned SizeW  = 24;
  localparam int unsigned DispW  = 24;
  localparam int unsigned DistW  = CoordW + 2;           // edge differences
  localparam int unsigned FracW  = 16;                   // Q8.16 time fraction
  localparam int unsigned NumW   = DistW + FracW;        // dividend magnitude
  localparam int unsigned DenW   = DispW;                // divisor magnitude
  localparam int unsigned TimeW  = NumW + 2;             // signed time, room for infinities
  localparam int unsigned OutW   = 24;
  localparam int unsigned NLanes = 4;

  localparam int unsigned LaneXIn  = 0;
  localparam int unsigned LaneXOut = 1;
  localparam int unsigned LaneYIn  = 2;
  localparam int unsigned LaneYOut = 3;

  localparam logic signed [TimeW-1:0] TimeOne    = TimeW'(65536);
  localparam logic signed [TimeW-1:0] TimeNegInf = -(TimeW'(1) <<< (TimeW - 2));
  localparam logic signed [TimeW-1:0] TimePosInf = (TimeW'(1) <<< (TimeW - 2));
  localparam logic signed [TimeW-1:0] OutMin     = -(TimeW'(1) <<< (OutW - 1));
  localparam logic signed [TimeW-1:0] OutMax     = (TimeW'(1) <<< (OutW - 1)) - TimeW'(1);

  localparam logic signed [1:0] NrmPos  = 2'sb01;
  localparam logic signed [1:0] NrmNeg  = 2'sb11;
  localparam logic signed [1:0] NrmZero = 2'sb00;

  typedef struct packed {
    logic [NLanes-1:0] neg;      // quotient sign per lane
    logic              zx;       // dx == 0
    logic              zy;       // dy == 0
    logic              hov;      // horizontal overlap now
    logic              vov;      // vertical overlap now
    logic              dx_pos;
    logic              dy_neg;
  } side_t;

endpackage

// ===== rtl/sbct_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, unsigned.
// Depends on sbct_pkg for widths.
module sbct_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic [sbct_pkg::NumW-1:0]    num_i,
  input  logic [sbct_pkg::DenW-1:0]    den_i,
  output logic [sbct_pkg::NumW-1:0]    quo_o
);

  localparam int unsigned NW = sbct_pkg::NumW;
  localparam int unsigned DW = sbct_pkg::DenW;

  logic [DW-1:0] rem_q [NW];
  logic [NW-1:0] nq_q  [NW];
  logic [DW-1:0] den_q [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [NW-1:0] nq_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num_i;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign nq_in  = nq_q[k-1];
      assign den_in = den_q[k-1];
    end

    assign trial = {rem_in, nq_in[NW-1]};
    assign ge    = trial >= {1'b0, den_in};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rem_q[k] <= '0;
      end else if (en_i) begin
        rem_q[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq_q[k]  <= {nq_in[NW-2:0], ge};
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = nq_q[NW-1];

endmodule

// ===== rtl/swept_box_collision_time_top.sv =====
// Swept box collision time, top level.
// Depends on sbct_pkg and sbct_div (four divider lanes).
//
// Usage:
//   One box pair enters on the input channel (in_valid_i / in_ready_o) and
//   one result leaves on the output channel (out_valid_o / out_ready_i).
//   Results come out in input order, one per pair.
//   From acceptance to out_valid_o a pair passes one setup stage,
//   50 divider stages at one quotient bit each, two compare stages and the
//   output register. Throughput: one pair per cycle while the output is not stalled.
//   The four axis times are computed by four parallel pipelined dividers;
//   their quotient width sets the depth.
//   The whole pipeline advances as one: while out_valid_o is high and
//   out_ready_i is low, every stage holds and in_ready_o is low. Nothing is
//   lost or repeated across a stall.
//   Reset clears all valid bits; the pipeline is empty and ready at once.
//   A zero displacement on an axis yields infinite entry/exit times on that
//   axis; a miss returns entry_time 1.0 (65536), zero normal and no_hit.
module swept_box_collision_time_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] mover_x_i,
  input  logic signed [31:0] mover_y_i,
  input  logic [23:0]        mover_width_i,
  input  logic [23:0]        mover_height_i,
  input  logic signed [23:0] mover_dx_i,
  input  logic signed [23:0] mover_dy_i,
  input  logic signed [31:0] target_x_i,
  input  logic signed [31:0] target_y_i,
  input  logic [23:0]        target_width_i,
  input  logic [23:0]        target_height_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [23:0] entry_time_o,
  output logic signed [1:0]  normal_x_o,
  output logic signed [1:0]  normal_y_o,
  output logic               no_hit_o
);

  localparam int unsigned DW   = sbct_pkg::DistW;
  localparam int unsigned NW   = sbct_pkg::NumW;
  localparam int unsigned QW   = sbct_pkg::DenW;
  localparam int unsigned TW   = sbct_pkg::TimeW;
  localparam int unsigned NL   = sbct_pkg::NLanes;
  localparam int unsigned FW   = sbct_pkg::FracW;

  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // setup: edge differences, magnitudes, signs, overlap
  logic signed [DW-1:0] mx, my, mw, mh, sx, sy, sw, sh;
  logic signed [DW-1:0] a1, a2, b1, b2;
  logic signed [DW-1:0] gap [NL];
  logic [DW-1:0]        dmag [NL];
  logic                 dx_pos, dy_pos, dx_zero, dy_zero;
  logic [QW-1:0]        dxm, dym;
  sbct_pkg::side_t      side_d;

  always_comb begin
    mx = DW'(mover_x_i);
    my = DW'(mover_y_i);
    sx = DW'(target_x_i);
    sy = DW'(target_y_i);
    mw = $signed({{(DW-24){1'b0}}, mover_width_i});
    mh = $signed({{(DW-24){1'b0}}, mover_height_i});
    sw = $signed({{(DW-24){1'b0}}, target_width_i});
    sh = $signed({{(DW-24){1'b0}}, target_height_i});
    a1 = sx - (mx + mw);
    a2 = (sx + sw) - mx;
    b1 = sy - (my - mh);
    b2 = (sy - sh) - my;
    dx_zero = mover_dx_i == '0;
    dy_zero = mover_dy_i == '0;
    dx_pos  = !mover_dx_i[23] && !dx_zero;
    dy_pos  = !mover_dy_i[23] && !dy_zero;
    dxm = mover_dx_i[23] ? QW'(-mover_dx_i) : QW'(mover_dx_i);
    dym = mover_dy_i[23] ? QW'(-mover_dy_i) : QW'(mover_dy_i);
    gap[sbct_pkg::LaneXIn]  = dx_pos ? a1 : a2;
    gap[sbct_pkg::LaneXOut] = dx_pos ? a2 : a1;
    gap[sbct_pkg::LaneYIn]  = dy_pos ? b1 : b2;
    gap[sbct_pkg::LaneYOut] = dy_pos ? b2 : b1;
    for (int i = 0; i < NL; i++) begin
      dmag[i] = gap[i][DW-1] ? DW'(-gap[i]) : DW'(gap[i]);
    end
    side_d.neg[sbct_pkg::LaneXIn]  = gap[sbct_pkg::LaneXIn][DW-1]  ^ mover_dx_i[23];
    side_d.neg[sbct_pkg::LaneXOut] = gap[sbct_pkg::LaneXOut][DW-1] ^ mover_dx_i[23];
    side_d.neg[sbct_pkg::LaneYIn]  = gap[sbct_pkg::LaneYIn][DW-1]  ^ dy_pos;
    side_d.neg[sbct_pkg::LaneYOut] = gap[sbct_pkg::LaneYOut][DW-1] ^ dy_pos;
    side_d.zx     = dx_zero;
    side_d.zy     = dy_zero;
    side_d.hov    = (a2 > 0) && (a1 < 0);
    side_d.vov    = (b2 < 0) && (b1 > 0);
    side_d.dx_pos = dx_pos;
    side_d.dy_neg = mover_dy_i[23];
  end

  logic            s1_vld_q;
  sbct_pkg::side_t s1_side_q;
  logic [NW-1:0]   s1_num_q [NL];
  logic [QW-1:0]   s1_dxm_q, s1_dym_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_side_q <= side_d;
      s1_dxm_q  <= dxm;
      s1_dym_q  <= dym;
      for (int i = 0; i < NL; i++) begin
        s1_num_q[i] <= {dmag[i], {FW{1'b0}}};
      end
    end
  end

  // divider lanes
  logic [NW-1:0] quo [NL];

  for (genvar l = 0; l < NL; l++) begin : g_lane
    sbct_div u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .num_i  (s1_num_q[l]),
      .den_i  ((l < 2) ? s1_dxm_q : s1_dym_q),
      .quo_o  (quo[l])
    );
  end

  // sidecar alongside the dividers
  logic            dl_vld_q  [NW];
  sbct_pkg::side_t dl_side_q [NW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NW; i++) dl_vld_q[i] <= 1'b0;
    end else if (adv) begin
      dl_vld_q[0] <= s1_vld_q;
      for (int i = 1; i < NW; i++) dl_vld_q[i] <= dl_vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dl_side_q[0] <= s1_side_q;
      for (int i = 1; i < NW; i++) dl_side_q[i] <= dl_side_q[i-1];
    end
  end

  // stage A: signed times with infinities
  sbct_pkg::side_t      dv_side;
  logic signed [TW-1:0] tm_d [NL];
  logic signed [TW-1:0] ta_q [NL];
  logic                 sa_vld_q;
  sbct_pkg::side_t      sa_side_q;

  always_comb begin
    dv_side = dl_side_q[NW-1];
    for (int i = 0; i < NL; i++) begin
      tm_d[i] = dv_side.neg[i] ? -$signed({2'b00, quo[i]}) : $signed({2'b00, quo[i]});
    end
    if (dv_side.zx) begin
      tm_d[sbct_pkg::LaneXIn]  = sbct_pkg::TimeNegInf;
      tm_d[sbct_pkg::LaneXOut] = sbct_pkg::TimePosInf;
    end
    if (dv_side.zy) begin
      tm_d[sbct_pkg::LaneYIn]  = sbct_pkg::TimeNegInf;
      tm_d[sbct_pkg::LaneYOut] = sbct_pkg::TimePosInf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_vld_q <= 1'b0;
    end else if (adv) begin
      sa_vld_q <= dl_vld_q[NW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sa_side_q <= dv_side;
      for (int i = 0; i < NL; i++) ta_q[i] <= tm_d[i];
    end
  end

  // stage B: entry max, exit min, late-entry flags
  logic                 sb_vld_q;
  sbct_pkg::side_t      sb_side_q;
  logic signed [TW-1:0] sb_tin_q, sb_tout_q;
  logic                 sb_late_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_vld_q <= 1'b0;
    end else if (adv) begin
      sb_vld_q <= sa_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb_side_q <= sa_side_q;
      sb_tin_q  <= (ta_q[sbct_pkg::LaneXIn] > ta_q[sbct_pkg::LaneYIn]) ?
                   ta_q[sbct_pkg::LaneXIn] : ta_q[sbct_pkg::LaneYIn];
      sb_tout_q <= (ta_q[sbct_pkg::LaneXOut] < ta_q[sbct_pkg::LaneYOut]) ?
                   ta_q[sbct_pkg::LaneXOut] : ta_q[sbct_pkg::LaneYOut];
      sb_late_q <= (ta_q[sbct_pkg::LaneXIn] > sbct_pkg::TimeOne) ||
                   (ta_q[sbct_pkg::LaneYIn] > sbct_pkg::TimeOne);
    end
  end

  // output stage
  logic                 miss;
  logic signed [TW-1:0] sat;
  logic signed [23:0]   time_d;
  logic signed [1:0]    nx_d, ny_d;

  always_comb begin
    miss = sb_late_q || (sb_tin_q > sb_tout_q);
    if (sb_tin_q < sbct_pkg::OutMin) begin
      sat = sbct_pkg::OutMin;
    end else if (sb_tin_q > sbct_pkg::OutMax) begin
      sat = sbct_pkg::OutMax;
    end else begin
      sat = sb_tin_q;
    end
    nx_d = sbct_pkg::NrmZero;
    ny_d = sbct_pkg::NrmZero;
    if (miss) begin
      time_d = 24'(sbct_pkg::TimeOne);
    end else begin
      time_d = sat[23:0];
      if (sb_side_q.hov) begin
        ny_d = sb_side_q.dy_neg ? sbct_pkg::NrmPos : sbct_pkg::NrmNeg;
      end else if (sb_side_q.vov) begin
        nx_d = sb_side_q.dx_pos ? sbct_pkg::NrmNeg : sbct_pkg::NrmPos;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= sb_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      entry_time_o <= time_d;
      normal_x_o   <= nx_d;
      normal_y_o   <= ny_d;
      no_hit_o     <= miss;
    end
  end

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o) else $error("input stalled with empty output");

  a_miss_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && no_hit_o) |-> (entry_time_o == 24'sd65536 &&
     normal_x_o == sbct_pkg::NrmZero && normal_y_o == sbct_pkg::NrmZero))
    else $error("miss result malformed");

  a_single_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (normal_x_o == sbct_pkg::NrmZero || normal_y_o == sbct_pkg::NrmZero))
    else $error("both normal components set");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(entry_time_o)))
    else $error("output changed during stall");

endmodule

// ===== bench/sbct_checker.sv =====
`timescale 1ns / 1ps
// Watches both channels of swept_box_collision_time_top, predicts each result
// and compares it with what the block returns. Depends on sbct_pkg.
module sbct_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [31:0] mover_x_i,
  input  logic signed [31:0] mover_y_i,
  input  logic [23:0]        mover_width_i,
  input  logic [23:0]        mover_height_i,
  input  logic signed [23:0] mover_dx_i,
  input  logic signed [23:0] mover_dy_i,
  input  logic signed [31:0] target_x_i,
  input  logic signed [31:0] target_y_i,
  input  logic [23:0]        target_width_i,
  input  logic [23:0]        target_height_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [23:0] entry_time_i,
  input  logic signed [1:0]  normal_x_i,
  input  logic signed [1:0]  normal_y_i,
  input  logic               no_hit_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic signed [23:0] entry_time;
    logic signed [1:0]  normal_x;
    logic signed [1:0]  normal_y;
    logic               no_hit;
  } contact_t;

  localparam longint TOne   = 65536;
  localparam longint NegInf = -(longint'(1) <<< 60);
  localparam longint PosInf = longint'(1) <<< 60;

  contact_t expected_contacts[$];

  function automatic longint sweep_time(longint gap, longint disp, longint if_still);
    if (disp == 0) return if_still;
    return (gap * 65536) / disp;
  endfunction

  function automatic contact_t predict_contact(
    longint mx, longint my, longint mw, longint mh, longint dx, longint dy,
    longint sx, longint sy, longint sw, longint sh);
    longint ml, mr, mt, mb, sl, sr, st, sb;
    longint x_in, x_out, y_in, y_out, tx_in, tx_out, ty_in, ty_out, t_in, t_out;
    contact_t c;
    ml = mx; mr = mx + mw; mt = my; mb = my - mh;
    sl = sx; sr = sx + sw; st = sy; sb = sy - sh;
    if (dx > 0) begin
      x_in = sl - mr; x_out = sr - ml;
    end else begin
      x_in = sr - ml; x_out = sl - mr;
    end
    if (dy > 0) begin
      y_in = st - mb; y_out = sb - mt;
    end else begin
      y_in = sb - mt; y_out = st - mb;
    end
    tx_in  = sweep_time(x_in, dx, NegInf);
    tx_out = sweep_time(x_out, dx, PosInf);
    ty_in  = sweep_time(y_in, -dy, NegInf);
    ty_out = sweep_time(y_out, -dy, PosInf);
    t_in  = (tx_in > ty_in) ? tx_in : ty_in;
    t_out = (tx_out < ty_out) ? tx_out : ty_out;
    c.normal_x = sbct_pkg::NrmZero;
    c.normal_y = sbct_pkg::NrmZero;
    if (t_in > t_out || tx_in > TOne || ty_in > TOne) begin
      c.entry_time = 24'sd65536;
      c.no_hit = 1'b1;
    end else begin
      c.no_hit = 1'b0;
      if (t_in < -8388608) t_in = -8388608;
      if (t_in > 8388607) t_in = 8388607;
      c.entry_time = t_in[23:0];
      if (ml < sr && mr > sl) begin
        c.normal_y = (dy < 0) ? sbct_pkg::NrmPos : sbct_pkg::NrmNeg;
      end else if (mt > sb && mb < st) begin
        c.normal_x = (dx > 0) ? sbct_pkg::NrmNeg : sbct_pkg::NrmPos;
      end
    end
    return c;
  endfunction

  assign pending_o = expected_contacts.size();

  always @(posedge clk_i or negedge rst_ni) begin
    contact_t want, got;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        expected_contacts.push_back(predict_contact(
          mover_x_i, mover_y_i, longint'(mover_width_i), longint'(mover_height_i),
          mover_dx_i, mover_dy_i, target_x_i, target_y_i,
          longint'(target_width_i), longint'(target_height_i)));
      end
      if (out_valid_i && out_ready_i) begin
        got = '{entry_time_i, normal_x_i, normal_y_i, no_hit_i};
        if (expected_contacts.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result %p", got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_contacts.pop_front();
          if (got !== want) begin
            if (fail_count_o < 10) $display("mismatch: expected %p got %p", want, got);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for swept_box_collision_time_top: makes box pairs, random
// idling and back-pressure, gives the verdict. Depends on sbct_checker.
module tb;

  typedef struct {
    logic signed [31:0] mx, my;
    logic [23:0]        mw, mh;
    logic signed [23:0] dx, dy;
    logic signed [31:0] sx, sy;
    logic [23:0]        sw, sh;
  } box_pair_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0, out_ready = 1'b0;
  logic in_ready, out_valid, no_hit;
  logic signed [31:0] mover_x = '0, mover_y = '0, target_x = '0, target_y = '0;
  logic [23:0] mover_width = '0, mover_height = '0, target_width = '0, target_height = '0;
  logic signed [23:0] mover_dx = '0, mover_dy = '0, entry_time;
  logic signed [1:0] normal_x, normal_y;
  int fail_count, pending;
  int send_idle_pct = 20, recv_stall_pct = 68;
  int hold_req = 0, hold_seen = 0, hold_left = 0;

  always #5 clk_i = ~clk_i;

  swept_box_collision_time_top u_dut (
    .clk_i, .rst_ni, .in_valid_i(in_valid), .in_ready_o(in_ready),
    .mover_x_i(mover_x), .mover_y_i(mover_y), .mover_width_i(mover_width),
    .mover_height_i(mover_height), .mover_dx_i(mover_dx), .mover_dy_i(mover_dy),
    .target_x_i(target_x), .target_y_i(target_y), .target_width_i(target_width),
    .target_height_i(target_height), .out_valid_o(out_valid), .out_ready_i(out_ready),
    .entry_time_o(entry_time), .normal_x_o(normal_x), .normal_y_o(normal_y),
    .no_hit_o(no_hit)
  );

  sbct_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i(in_valid), .in_ready_i(in_ready),
    .mover_x_i(mover_x), .mover_y_i(mover_y), .mover_width_i(mover_width),
    .mover_height_i(mover_height), .mover_dx_i(mover_dx), .mover_dy_i(mover_dy),
    .target_x_i(target_x), .target_y_i(target_y), .target_width_i(target_width),
    .target_height_i(target_height), .out_valid_i(out_valid), .out_ready_i(out_ready),
    .entry_time_i(entry_time), .normal_x_i(normal_x), .normal_y_i(normal_y),
    .no_hit_i(no_hit), .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver: random stalls, plus a long hold when requested
  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_pair(input box_pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    mover_x <= p.mx; mover_y <= p.my; mover_width <= p.mw; mover_height <= p.mh;
    mover_dx <= p.dx; mover_dy <= p.dy;
    target_x <= p.sx; target_y <= p.sy; target_width <= p.sw; target_height <= p.sh;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  function automatic box_pair_t pair_of(int mx, int my, int mw, int mh, int dx, int dy,
                                        int sx, int sy, int sw, int sh);
    box_pair_t p;
    p.mx = mx; p.my = my; p.mw = 24'(mw); p.mh = 24'(mh); p.dx = 24'(dx); p.dy = 24'(dy);
    p.sx = sx; p.sy = sy; p.sw = 24'(sw); p.sh = 24'(sh);
    return p;
  endfunction

  function automatic int small_offset(int span);
    return $signed($urandom_range(2 * span)) - span;
  endfunction

  function automatic box_pair_t random_pair();
    box_pair_t p;
    int kind;
    kind = $urandom_range(99);
    if (kind < 25) begin
      p.mx = $urandom; p.my = $urandom; p.mw = 24'($urandom); p.mh = 24'($urandom);
      p.dx = 24'($urandom); p.dy = 24'($urandom); p.sx = $urandom; p.sy = $urandom;
      p.sw = 24'($urandom); p.sh = 24'($urandom);
    end else begin
      p.mx = $urandom; p.my = $urandom;
      if (kind < 35) begin
        p.mx = small_offset(4000); p.my = small_offset(4000);
      end
      p.mw = 24'($urandom_range(6000)); p.mh = 24'($urandom_range(6000));
      p.sw = 24'($urandom_range(6000)); p.sh = 24'($urandom_range(6000));
      p.sx = p.mx + small_offset(16000);
      p.sy = p.my + small_offset(16000);
      p.dx = ($urandom_range(5) == 0) ? '0 : 24'(small_offset(20000));
      p.dy = ($urandom_range(5) == 0) ? '0 : 24'(small_offset(20000));
      if (kind > 94) begin
        p.dx = 24'($urandom); p.dy = 24'($urandom);
      end
    end
    return p;
  endfunction

  initial begin
    box_pair_t directed[$];
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    directed.push_back(pair_of(0, 0, 256, 256, 0, 0, 0, 0, 256, 256));     // still, overlap
    directed.push_back(pair_of(0, 0, 256, 256, 0, 0, 5000, 0, 256, 256));  // still, apart
    directed.push_back(pair_of(0, 0, 256, 256, 512, 0, 512, 0, 256, 256)); // hit from left
    directed.push_back(pair_of(600, 0, 256, 256, -512, 0, 0, 0, 256, 256)); // from right
    directed.push_back(pair_of(0, 600, 256, 256, 0, 512, 0, 0, 256, 256)); // moving up
    directed.push_back(pair_of(0, 0, 256, 256, 0, -512, 0, 600, 256, 256)); // moving down
    directed.push_back(pair_of(0, 0, 256, 256, 100, 0, 9000, 0, 256, 256)); // too far
    directed.push_back(pair_of(0, 0, 256, 256, 256, 0, 256, 0, 256, 256)); // touch at 0.0
    directed.push_back(pair_of(0, 0, 256, 256, 1, 1, 0, 0, 256, 256));     // deep overlap
    directed.push_back(pair_of(0, 0, 0, 0, 256, -256, 128, -128, 0, 0));   // zero sizes
    directed.push_back(pair_of(32'sh7fffffff, 32'sh7fffffff, 24'hffffff, 24'hffffff,
                               24'sh7fffff, 24'sh7fffff, 32'sh80000000, 32'sh80000000,
                               24'hffffff, 24'hffffff));
    directed.push_back(pair_of(32'sh80000000, 32'sh80000000, 24'hffffff, 24'hffffff,
                               24'sh800000, 24'sh800000, 32'sh7fffffff, 32'sh7fffffff,
                               24'hffffff, 24'hffffff));
    directed.push_back(pair_of(0, 0, 24'hffffff, 24'hffffff, 1, 0, 0, 0, 24'hffffff, 0));
    directed.push_back(pair_of(-256, 0, 256, 256, 1, 0, 0, 0, 256, 256));  // tiny step
    directed.push_back(pair_of(0, 0, 256, 256, -1, 0, 24'hffffff, 0, 256, 256));
    directed.push_back(pair_of(0, 0, 256, 256, 300, 300, 400, -400, 256, 256)); // diagonal
    foreach (directed[i]) send_pair(directed[i]);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct  = (phase == 0) ? 20 : (phase == 1) ? 68 : 0;
      recv_stall_pct = (phase == 0) ? 68 : (phase == 1) ? 20 : 0;
      if (phase == 2) begin
        @(negedge clk_i);
        in_valid <= 1'b0;
        wait (pending == 0);
        hold_req = hold_req + 1;
      end
      repeat (460) send_pair(random_pair());
    end
    @(negedge clk_i);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0) $display("** swept_box_collision_time_top: PASSED **");
    else $display("** swept_box_collision_time_top: FAILED **");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("** swept_box_collision_time_top: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sbct_pkg.sv
rtl/sbct_div.sv
rtl/swept_box_collision_time_top.sv
bench/sbct_checker.sv
bench/tb.sv
